@@ rtl/core/csrd_pkg.sv @@
// Shared types and codes for the column sprite RLE decoder.
// Holds the item structs, the result codes and the controller/datapath interface.
// Depends on nothing; every other file imports it.
package csrd_pkg;

    localparam int C_MAX_WIDTH  = 1024;
    localparam int C_MAX_HEIGHT = 1024;
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 11;

    typedef logic [2:0] t_kind;
    localparam t_kind K_PIXEL = 3'd0;
    localparam t_kind K_FULL  = 3'd1;
    localparam t_kind K_COPY  = 3'd2;
    localparam t_kind K_DONE  = 3'd3;
    localparam t_kind K_ERROR = 3'd4;

    typedef logic [2:0] t_err;
    localparam t_err E_NONE   = 3'd0;
    localparam t_err E_CODE   = 3'd1;
    localparam t_err E_DIR    = 3'd2;
    localparam t_err E_RUN0   = 3'd3;
    localparam t_err E_YRANGE = 3'd4;
    localparam t_err E_COLOR  = 3'd5;

    typedef logic [1:0] t_cnt_op;
    localparam t_cnt_op CNT_HOLD = 2'd0;
    localparam t_cnt_op CNT_LOAD = 2'd1;
    localparam t_cnt_op CNT_DEC  = 2'd2;

    typedef logic [1:0] t_y_op;
    localparam t_y_op Y_HOLD = 2'd0;
    localparam t_y_op Y_ZERO = 2'd1;
    localparam t_y_op Y_ADD  = 2'd2;
    localparam t_y_op Y_INC  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       first_frame;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [9:0] column;
        logic [9:0] row;
        logic [7:0] color;
        t_err       error_code;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    rle_load;
        logic    run_load;
        logic    run_dec;
        logic    col_inc;
        logic    raw_inc;
        t_cnt_op col_op;
        t_cnt_op seq_op;
        t_y_op   y_op;
        logic    emit;
        t_kind   kind;
        t_err    err;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        logic fs;
        logic ff;
        logic raw_mode;
        logic b_zero;
        logic b_one;
        logic b_ff;
        logic b_dir;
        logic b_ge_e0;
        logic rle;
        logic w_zero;
        logic h_zero;
        logic col_last;
        logic y_out;
        logic color_bad;
        logic col_zero;
        logic col_zero_dec;
        logic seq_zero;
        logic seq_zero_dec;
        logic run_last;
        logic raw_pre_last;
        logic raw_y_last;
        logic slot;
    } t_dp_status;

endpackage

@@ rtl/core/csrd_datapath.sv @@
// Datapath of the column sprite RLE decoder: configuration registers, frame
// counters, the latched input byte and the output register.
// Depends on csrd_pkg; driven by csrd_ctrl through t_dp_cmd.
module csrd_datapath import csrd_pkg::*; #(
    parameter int RAW_PREAMBLE = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item                i_in_item,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output t_out_item               o_out_item,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status
);

    localparam int RAW_W = (RAW_PREAMBLE < 2) ? 1 : $clog2(RAW_PREAMBLE + 1);
    localparam logic [RAW_W:0] PRE_END = RAW_PREAMBLE[RAW_W:0];

    localparam logic [C_CFG_IDX_W-1:0] R_WIDTH   = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] R_HEIGHT  = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] R_PALETTE = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] R_TRANSP  = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] R_RAW     = 3'd4;

    localparam logic [10:0] W_CLIP = (C_MAX_WIDTH > 2047) ? 11'h7FF : C_MAX_WIDTH[10:0];
    localparam logic [10:0] H_CLIP = (C_MAX_HEIGHT > 2047) ? 11'h7FF : C_MAX_HEIGHT[10:0];

    localparam logic [7:0] B_RUN_MIN = 8'hE0;
    localparam logic [7:0] B_EMPTY   = 8'hFF;
    localparam logic [7:0] B_PLAIN   = 8'h00;
    localparam logic [7:0] B_RLE     = 8'h80;

    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [8:0]  r_palette;
    logic [7:0]  r_transp;
    logic        r_raw_mode;

    logic [7:0]       r_byte;
    logic             r_fs;
    logic             r_ff;
    logic [10:0]      r_col;
    logic [10:0]      r_y;
    logic [7:0]       r_col_left;
    logic [7:0]       r_seq_left;
    logic             r_rle;
    logic [5:0]       r_run;
    logic [RAW_W-1:0] r_raw;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [10:0]      w_eff_w;
    logic [10:0]      w_eff_h;
    logic [10:0]      w_col_next;
    logic [11:0]      w_y_sum;
    logic [11:0]      w_y_next;
    logic [RAW_W:0]   w_raw_next;
    logic [RAW_W-1:0] n_raw;
    t_out_item        w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 11'd320;
            r_height   <= 11'd200;
            r_palette  <= 9'd256;
            r_transp   <= 8'd0;
            r_raw_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                R_WIDTH:   r_width    <= i_cfg_data;
                R_HEIGHT:  r_height   <= i_cfg_data;
                R_PALETTE: r_palette  <= i_cfg_data[8:0];
                R_TRANSP:  r_transp   <= i_cfg_data[7:0];
                R_RAW:     r_raw_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_eff_w    = (r_width < W_CLIP) ? r_width : W_CLIP;
    assign w_eff_h    = (r_height < H_CLIP) ? r_height : H_CLIP;
    assign w_col_next = r_col + 11'd1;
    assign w_y_sum    = {1'b0, r_y} + {4'b0, r_byte};
    assign w_y_next   = {1'b0, r_y} + 12'd1;
    assign w_raw_next = {1'b0, r_raw} + {{RAW_W{1'b0}}, 1'b1};

    always_comb begin
        n_raw = i_cmd.clear ? '0 : r_raw;
        if (i_cmd.raw_inc) begin
            n_raw = n_raw + {{(RAW_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_in_item.data_byte;
            r_fs   <= i_in_item.frame_start;
            r_ff   <= i_in_item.first_frame;
        end
        r_raw <= n_raw;
        if (i_cmd.clear) begin
            r_col      <= '0;
            r_y        <= '0;
            r_col_left <= '0;
            r_seq_left <= '0;
            r_rle      <= 1'b0;
            r_run      <= '0;
        end else begin
            if (i_cmd.col_inc) begin
                r_col <= w_col_next;
            end
            unique case (i_cmd.y_op)
                Y_HOLD: ;
                Y_ZERO: r_y <= '0;
                Y_ADD:  r_y <= w_y_sum[11] ? 11'h7FF : w_y_sum[10:0];
                Y_INC:  r_y <= w_y_next[10:0];
                default: ;
            endcase
            unique case (i_cmd.col_op)
                CNT_LOAD: r_col_left <= r_byte;
                CNT_DEC:  if (r_col_left != 8'd0) r_col_left <= r_col_left - 8'd1;
                default: ;
            endcase
            unique case (i_cmd.seq_op)
                CNT_LOAD: r_seq_left <= r_byte;
                CNT_DEC:  if (r_seq_left != 8'd0) r_seq_left <= r_seq_left - 8'd1;
                default: ;
            endcase
            if (i_cmd.rle_load) begin
                r_rle <= r_byte[7];
            end
            if (i_cmd.run_load) begin
                r_run <= {1'b0, r_byte[4:0]} + 6'd1;
            end else if (i_cmd.run_dec) begin
                r_run <= r_run - 6'd1;
            end
        end
    end

    always_comb begin
        w_out            = '0;
        w_out.kind       = i_cmd.kind;
        w_out.error_code = i_cmd.err;
        w_out.last       = i_cmd.last;
        if (i_cmd.kind == K_PIXEL) begin
            w_out.column = r_col[9:0];
            w_out.row    = r_y[9:0];
            w_out.color  = r_byte;
        end else if (i_cmd.kind == K_FULL) begin
            w_out.color  = r_transp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_status.fs           = r_fs;
    assign o_status.ff           = r_ff;
    assign o_status.raw_mode     = r_raw_mode;
    assign o_status.b_zero       = (r_byte == B_PLAIN);
    assign o_status.b_one        = (r_byte == 8'd1);
    assign o_status.b_ff         = (r_byte == B_EMPTY);
    assign o_status.b_dir        = (r_byte == B_PLAIN) || (r_byte == B_RLE);
    assign o_status.b_ge_e0      = (r_byte >= B_RUN_MIN);
    assign o_status.rle          = r_rle;
    assign o_status.w_zero       = (w_eff_w == 11'd0);
    assign o_status.h_zero       = (w_eff_h == 11'd0);
    assign o_status.col_last     = (w_col_next >= w_eff_w);
    assign o_status.y_out        = (r_y >= w_eff_h);
    assign o_status.color_bad    = ({1'b0, r_byte} >= r_palette);
    assign o_status.col_zero     = (r_col_left == 8'd0);
    assign o_status.col_zero_dec = (r_col_left <= 8'd1);
    assign o_status.seq_zero     = (r_seq_left == 8'd0);
    assign o_status.seq_zero_dec = (r_seq_left <= 8'd1);
    assign o_status.run_last     = (r_run == 6'd1);
    assign o_status.raw_pre_last = (w_raw_next >= PRE_END);
    assign o_status.raw_y_last   = (w_y_next >= {1'b0, w_eff_h});
    assign o_status.slot         = !r_out_valid || i_out_ready;

endmodule

@@ rtl/core/csrd_ctrl.sv @@
// Controller of the column sprite RLE decoder: frame phase and item sequencing.
// Depends on csrd_pkg; commands csrd_datapath and reads its status.
module csrd_ctrl import csrd_pkg::*; #(
    parameter int RAW_PREAMBLE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] U_WAIT = 3'd0;
    localparam logic [2:0] U_EXEC = 3'd1;
    localparam logic [2:0] U_RUN  = 3'd2;
    localparam logic [2:0] U_RAW  = 3'd3;
    localparam logic [2:0] U_DONE = 3'd4;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_DIR    = 4'd1;
    localparam logic [3:0] PH_ROWB   = 4'd2;
    localparam logic [3:0] PH_SEQ    = 4'd3;
    localparam logic [3:0] PH_DELTA  = 4'd4;
    localparam logic [3:0] PH_PIX    = 4'd5;
    localparam logic [3:0] PH_RUN    = 4'd6;
    localparam logic [3:0] PH_RAWPRE = 4'd7;
    localparam logic [3:0] PH_RAWPIX = 4'd8;
    localparam logic [3:0] PH_DONE   = 4'd9;

    localparam bit PRE_NONE = (RAW_PREAMBLE == 0);
    localparam bit PRE_ONE  = (RAW_PREAMBLE == 1);

    logic [2:0] r_ustate;
    logic [2:0] n_ustate;
    logic [3:0] r_phase;
    logic [3:0] n_phase;
    logic       w_raw_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ustate <= U_WAIT;
            r_phase  <= PH_IDLE;
        end else begin
            r_ustate <= n_ustate;
            r_phase  <= n_phase;
        end
    end

    assign o_in_ready = (r_ustate == U_WAIT);

    always_comb begin
        n_ustate   = r_ustate;
        n_phase    = r_phase;
        o_cmd      = '0;
        w_raw_step = 1'b0;
        unique case (r_ustate)
            U_WAIT: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_ustate   = U_EXEC;
                end
            end
            U_EXEC: begin
                if (i_status.slot) begin
                    n_ustate = U_WAIT;
                    if (i_status.fs) begin
                        o_cmd.clear = 1'b1;
                        if (i_status.raw_mode) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = K_FULL;
                            if (PRE_NONE) begin
                                n_phase  = PH_RAWPIX;
                                n_ustate = U_RAW;
                            end else begin
                                o_cmd.last    = 1'b1;
                                o_cmd.raw_inc = 1'b1;
                                n_phase       = PRE_ONE ? PH_RAWPIX : PH_RAWPRE;
                            end
                        end else if (i_status.b_one || (i_status.b_zero && !i_status.ff)) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = i_status.b_one ? K_FULL : K_COPY;
                            if (i_status.w_zero) begin
                                n_phase  = PH_DONE;
                                n_ustate = U_DONE;
                            end else begin
                                o_cmd.last = 1'b1;
                                n_phase    = PH_DIR;
                            end
                        end else begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = K_ERROR;
                            o_cmd.err  = E_CODE;
                            o_cmd.last = 1'b1;
                            n_phase    = PH_DONE;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_DIR: begin
                                priority if (i_status.b_ff) begin
                                    o_cmd.col_inc = 1'b1;
                                    if (i_status.col_last) begin
                                        o_cmd.emit = 1'b1;
                                        o_cmd.kind = K_DONE;
                                        o_cmd.last = 1'b1;
                                        n_phase    = PH_DONE;
                                    end else begin
                                        n_phase = PH_DIR;
                                    end
                                end else if (i_status.b_dir) begin
                                    o_cmd.rle_load = 1'b1;
                                    n_phase        = PH_ROWB;
                                end else begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.kind = K_ERROR;
                                    o_cmd.err  = E_DIR;
                                    o_cmd.last = 1'b1;
                                    n_phase    = PH_DONE;
                                end
                            end
                            PH_ROWB: begin
                                o_cmd.col_op = CNT_LOAD;
                                o_cmd.y_op   = Y_ZERO;
                                if (i_status.b_zero) begin
                                    o_cmd.col_inc = 1'b1;
                                    if (i_status.col_last) begin
                                        o_cmd.emit = 1'b1;
                                        o_cmd.kind = K_DONE;
                                        o_cmd.last = 1'b1;
                                        n_phase    = PH_DONE;
                                    end else begin
                                        n_phase = PH_DIR;
                                    end
                                end else begin
                                    n_phase = PH_SEQ;
                                end
                            end
                            PH_SEQ: begin
                                o_cmd.col_op = CNT_DEC;
                                o_cmd.seq_op = CNT_LOAD;
                                n_phase      = PH_DELTA;
                            end
                            PH_DELTA: begin
                                o_cmd.col_op = CNT_DEC;
                                o_cmd.y_op   = Y_ADD;
                                if (!i_status.seq_zero) begin
                                    n_phase = PH_PIX;
                                end else if (!i_status.col_zero_dec) begin
                                    n_phase = PH_SEQ;
                                end else begin
                                    o_cmd.col_inc = 1'b1;
                                    if (i_status.col_last) begin
                                        o_cmd.emit = 1'b1;
                                        o_cmd.kind = K_DONE;
                                        o_cmd.last = 1'b1;
                                        n_phase    = PH_DONE;
                                    end else begin
                                        n_phase = PH_DIR;
                                    end
                                end
                            end
                            PH_PIX: begin
                                o_cmd.col_op = CNT_DEC;
                                o_cmd.seq_op = CNT_DEC;
                                priority if (i_status.rle && i_status.b_ge_e0) begin
                                    o_cmd.run_load = 1'b1;
                                    n_phase        = PH_RUN;
                                end else if (i_status.y_out) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.kind = K_ERROR;
                                    o_cmd.err  = E_YRANGE;
                                    o_cmd.last = 1'b1;
                                    n_phase    = PH_DONE;
                                end else if (i_status.color_bad) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.kind = K_ERROR;
                                    o_cmd.err  = E_COLOR;
                                    o_cmd.last = 1'b1;
                                    n_phase    = PH_DONE;
                                end else begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.kind = K_PIXEL;
                                    o_cmd.y_op = Y_INC;
                                    o_cmd.last = 1'b1;
                                    if (i_status.seq_zero_dec) begin
                                        if (!i_status.col_zero_dec) begin
                                            n_phase = PH_SEQ;
                                        end else begin
                                            o_cmd.col_inc = 1'b1;
                                            if (i_status.col_last) begin
                                                o_cmd.last = 1'b0;
                                                n_phase    = PH_DONE;
                                                n_ustate   = U_DONE;
                                            end else begin
                                                n_phase = PH_DIR;
                                            end
                                        end
                                    end
                                end
                            end
                            PH_RUN: begin
                                o_cmd.col_op = CNT_DEC;
                                o_cmd.seq_op = CNT_DEC;
                                n_ustate     = U_RUN;
                            end
                            PH_RAWPRE: begin
                                o_cmd.raw_inc = 1'b1;
                                if (i_status.raw_pre_last) begin
                                    n_phase = PH_RAWPIX;
                                end
                            end
                            PH_RAWPIX: begin
                                w_raw_step = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            U_RAW: begin
                if (i_status.slot) begin
                    n_ustate   = U_WAIT;
                    w_raw_step = 1'b1;
                end
            end
            U_RUN: begin
                if (i_status.slot) begin
                    n_ustate = U_WAIT;
                    priority if (i_status.b_zero) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = K_ERROR;
                        o_cmd.err  = E_RUN0;
                        o_cmd.last = 1'b1;
                        n_phase    = PH_DONE;
                    end else if (i_status.y_out) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = K_ERROR;
                        o_cmd.err  = E_YRANGE;
                        o_cmd.last = 1'b1;
                        n_phase    = PH_DONE;
                    end else if (i_status.color_bad) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = K_ERROR;
                        o_cmd.err  = E_COLOR;
                        o_cmd.last = 1'b1;
                        n_phase    = PH_DONE;
                    end else begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.kind    = K_PIXEL;
                        o_cmd.y_op    = Y_INC;
                        o_cmd.run_dec = 1'b1;
                        if (!i_status.run_last) begin
                            n_ustate = U_RUN;
                        end else begin
                            o_cmd.last = 1'b1;
                            if (!i_status.seq_zero) begin
                                n_phase = PH_PIX;
                            end else if (!i_status.col_zero) begin
                                n_phase = PH_SEQ;
                            end else begin
                                o_cmd.col_inc = 1'b1;
                                if (i_status.col_last) begin
                                    o_cmd.last = 1'b0;
                                    n_phase    = PH_DONE;
                                    n_ustate   = U_DONE;
                                end else begin
                                    n_phase = PH_DIR;
                                end
                            end
                        end
                    end
                end
            end
            U_DONE: begin
                if (i_status.slot) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_DONE;
                    o_cmd.last = 1'b1;
                    n_ustate   = U_WAIT;
                end
            end
            default: begin
                n_ustate = U_WAIT;
            end
        endcase

        if (w_raw_step) begin
            o_cmd.emit = 1'b1;
            o_cmd.last = 1'b1;
            if (i_status.w_zero || i_status.h_zero) begin
                o_cmd.kind = K_DONE;
                n_phase    = PH_DONE;
            end else begin
                o_cmd.kind = K_PIXEL;
                if (i_status.raw_y_last) begin
                    o_cmd.y_op    = Y_ZERO;
                    o_cmd.col_inc = 1'b1;
                    if (i_status.col_last) begin
                        o_cmd.last = 1'b0;
                        n_phase    = PH_DONE;
                        n_ustate   = U_DONE;
                    end
                end else begin
                    o_cmd.y_op = Y_INC;
                end
            end
        end
    end

endmodule

@@ rtl/core/column_sprite_rle_decoder.sv @@
// Top level of the column sprite RLE decoder.
// Joins csrd_ctrl and csrd_datapath; types and codes come from csrd_pkg.
//
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_ready    i_in_item (t_in_item)
// out      out  o_out_valid / i_out_ready  o_out_item (t_out_item)
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A byte is latched in the wait state and decoded in the execute state; a byte that
// causes further results (such as a run byte) holds off new input until they are issued.
// The controller sequences one byte at a time; the output register holds one result.
// A stalled output register holds the controller in place; nothing is dropped.
// Reset is synchronous and loads the register defaults; there is no clearing pass.
module column_sprite_rle_decoder import csrd_pkg::*; #(
    parameter int RAW_PREAMBLE = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    csrd_ctrl #(
        .RAW_PREAMBLE(RAW_PREAMBLE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    csrd_datapath #(
        .RAW_PREAMBLE(RAW_PREAMBLE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

    a_one_item_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("input taken while the previous item is still in work");

    a_no_ready_mid_item: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |-> !o_in_ready
    ) else $error("input ready while results of an item are still pending");

    a_error_code_match: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.kind == K_ERROR) == (o_out_item.error_code != E_NONE))
    ) else $error("error code does not match result kind");

    a_coords_only_on_pixel: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.kind != K_PIXEL))
            |-> (o_out_item.column == 10'd0 && o_out_item.row == 10'd0)
    ) else $error("coordinates set on a result that is not a pixel");

endmodule
